// ----- src/assert_macros.svh -----
// Shared assertion macros for the line decoder checkers.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must be true at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// When the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_SAME(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pld_pkg.sv -----
package pld_pkg;

	// Field widths fixed by the stream format.
	localparam int LEN_W      = 13;
	localparam int POS_W      = 13;
	localparam int VALUE_W    = 32;
	localparam int INDEX_W    = 12;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 48;

	// Command codes carried in s_tuser.
	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Configuration register indexes.
	localparam logic REG_LINE_LENGTH  = 1'b0;
	localparam logic REG_ELEMENT_SIZE = 1'b1;

	// Element size codes.
	localparam logic [1:0] ESIZE_1 = 2'd0;
	localparam logic [1:0] ESIZE_2 = 2'd1;

	// Reset value of the line length register.
	localparam logic [LEN_W-1:0] LINE_LEN_RESET = 13'd4096;

	// Header byte -128, which decodes as a literal of one element.
	localparam logic [7:0] HDR_LITERAL_ONE = 8'h80;

	// One decoded input word.
	typedef struct packed {
		logic               command;
		logic [7:0]         data_byte;
		logic [INDEX_W-1:0] read_index;
	} item_t;

	// One result word.
	typedef struct packed {
		logic               line_done;
		logic               overflow_error;
		logic [POS_W-1:0]   fill_position;
		logic [VALUE_W-1:0] read_value;
	} result_t;

endpackage

// ----- src/pld_ram.sv -----
module pld_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/pld_core.sv -----
module pld_core #(
	parameter int MAX_LINE = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration writes.
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [pld_pkg::LEN_W-1:0]           cfg_data,
	// Input words.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pld_pkg::item_t                      in_item,
	// Results toward the output register.
	input  logic                                out_free,
	output logic                                res_valid,
	output pld_pkg::result_t                    res,
	// Line store port.
	output logic                                mem_we,
	output logic [$clog2(MAX_LINE)-1:0]         mem_waddr,
	output logic [pld_pkg::VALUE_W-1:0]         mem_wdata,
	output logic [$clog2(MAX_LINE)-1:0]         mem_raddr,
	input  logic [pld_pkg::VALUE_W-1:0]         mem_rdata
);

	localparam int AW = $clog2(MAX_LINE);
	localparam int FW = $clog2(MAX_LINE + 1);
	localparam int CW = (FW > pld_pkg::LEN_W) ? FW : pld_pkg::LEN_W;
	localparam int SW = (FW > 8) ? FW : 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WRITE,
		ST_READ,
		ST_HOLD
	} state_t;

	state_t                          state_q;
	logic [pld_pkg::LEN_W-1:0]       line_length_q;
	logic [1:0]                      esize_q;
	pld_pkg::item_t                  item_s1;
	logic [FW-1:0]                   fill_q;
	logic                            data_phase_q;
	logic [7:0]                      remain_q;
	logic                            run_q;
	logic [1:0]                      bytepos_q;
	logic [pld_pkg::VALUE_W-1:0]     gather_q;
	logic [7:0]                      copies_q;
	pld_pkg::result_t                res_q;

	logic [CW-1:0]                   len_ext;
	logic [CW-1:0]                   len_clamp;
	logic [FW-1:0]                   eff_len;
	logic [2:0]                      nbytes;
	logic                            elem_last;
	logic [pld_pkg::VALUE_W-1:0]     gather_new;
	logic [FW-1:0]                   space;
	logic [7:0]                      want;
	logic [7:0]                      copies;
	logic [FW-1:0]                   wr_fill_next;
	logic [7:0]                      wr_rem_next;
	logic                            pkt_end;
	logic                            line_full;
	logic                            line_over;
	logic                            read_in_range;

	// Effective line length, clamped to one at the low end and to the store depth.
	always_comb begin
		len_ext = CW'(line_length_q);
		if (len_ext == '0) begin
			len_clamp = CW'(1);
		end else if (len_ext > CW'(MAX_LINE)) begin
			len_clamp = CW'(MAX_LINE);
		end else begin
			len_clamp = len_ext;
		end
		eff_len = FW'(len_clamp);
	end

	// Element assembly: bytes are placed little-endian.
	always_comb begin
		case (esize_q)
			pld_pkg::ESIZE_1: nbytes = 3'd1;
			pld_pkg::ESIZE_2: nbytes = 3'd2;
			default:          nbytes = 3'd4;
		endcase
		elem_last  = ({1'b0, bytepos_q} + 3'd1) >= nbytes;
		gather_new = gather_q
			| (pld_pkg::VALUE_W'(item_s1.data_byte) << {bytepos_q, 3'b000});
	end

	// Copy count for a finished element, limited by the room left in the line.
	always_comb begin
		space = eff_len - fill_q;
		want  = run_q ? remain_q : 8'd1;
		if (SW'(want) > SW'(space)) begin
			copies = 8'(space);
		end else begin
			copies = want;
		end
		wr_fill_next = fill_q + 1'b1;
		wr_rem_next  = remain_q - 8'd1;
		pkt_end      = (wr_rem_next == 8'd0);
		line_full    = (wr_fill_next >= eff_len);
		line_over    = (fill_q >= eff_len);
		read_in_range = (32'(item_s1.read_index) < 32'(MAX_LINE));
	end

	// Store port: one write per cycle at the fill position, one read per read command.
	always_comb begin
		mem_we    = ((state_q == ST_EXEC) && (item_s1.command == pld_pkg::CMD_FEED)
			&& !line_over && data_phase_q && elem_last) || (state_q == ST_WRITE);
		mem_waddr = fill_q[AW-1:0];
		mem_wdata = (state_q == ST_WRITE) ? gather_q : gather_new;
		mem_raddr = AW'(item_s1.read_index);
	end

	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_HOLD) && out_free);
	assign res_valid = (state_q == ST_HOLD) && out_free;
	assign res       = res_q;

	// Sequencer, decode state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			line_length_q <= pld_pkg::LINE_LEN_RESET;
			esize_q       <= pld_pkg::ESIZE_1;
			item_s1       <= '0;
			fill_q        <= '0;
			data_phase_q  <= 1'b0;
			remain_q      <= '0;
			run_q         <= 1'b0;
			bytepos_q     <= '0;
			gather_q      <= '0;
			copies_q      <= '0;
			res_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pld_pkg::REG_LINE_LENGTH:  line_length_q <= cfg_data;
					pld_pkg::REG_ELEMENT_SIZE: esize_q <= cfg_data[1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE, ST_HOLD: begin
					if (in_valid && in_ready) begin
						item_s1 <= in_item;
						state_q <= ST_EXEC;
					end else if (state_q == ST_HOLD && out_free) begin
						state_q <= ST_IDLE;
					end
				end

				ST_EXEC: begin
					res_q.line_done      <= 1'b0;
					res_q.overflow_error <= 1'b0;
					res_q.read_value     <= '0;
					res_q.fill_position  <= pld_pkg::POS_W'(fill_q);
					state_q              <= ST_HOLD;
					if (item_s1.command == pld_pkg::CMD_READ) begin
						state_q <= ST_READ;
					end else if (line_over) begin
						// Line already full: drop the byte and restart the line.
						res_q.overflow_error <= 1'b1;
						res_q.fill_position  <= '0;
						fill_q       <= '0;
						data_phase_q <= 1'b0;
						remain_q     <= '0;
						run_q        <= 1'b0;
						bytepos_q    <= '0;
						gather_q     <= '0;
					end else if (!data_phase_q) begin
						// Packet header.
						if (item_s1.data_byte == pld_pkg::HDR_LITERAL_ONE) begin
							run_q    <= 1'b0;
							remain_q <= 8'd1;
						end else if (item_s1.data_byte[7]) begin
							run_q    <= 1'b1;
							remain_q <= 8'(9'd257 - {1'b0, item_s1.data_byte});
						end else begin
							run_q    <= 1'b0;
							remain_q <= item_s1.data_byte + 8'd1;
						end
						data_phase_q <= 1'b1;
						bytepos_q    <= '0;
						gather_q     <= '0;
					end else if (!elem_last) begin
						bytepos_q <= bytepos_q + 2'd1;
						gather_q  <= gather_new;
					end else begin
						// Element complete: first copy is written this cycle.
						fill_q    <= wr_fill_next;
						remain_q  <= wr_rem_next;
						bytepos_q <= '0;
						gather_q  <= gather_new;
						if (copies == 8'd1) begin
							gather_q            <= '0;
							res_q.fill_position <= pld_pkg::POS_W'(wr_fill_next);
							if (pkt_end) begin
								data_phase_q <= 1'b0;
								if (line_full) begin
									res_q.line_done     <= 1'b1;
									res_q.fill_position <= '0;
									fill_q              <= '0;
									run_q               <= 1'b0;
								end
							end
						end else begin
							copies_q <= copies - 8'd1;
							state_q  <= ST_WRITE;
						end
					end
				end

				ST_WRITE: begin
					fill_q   <= wr_fill_next;
					remain_q <= wr_rem_next;
					copies_q <= copies_q - 8'd1;
					if (copies_q == 8'd1) begin
						gather_q            <= '0;
						res_q.fill_position <= pld_pkg::POS_W'(wr_fill_next);
						state_q             <= ST_HOLD;
						if (pkt_end) begin
							data_phase_q <= 1'b0;
							if (line_full) begin
								res_q.line_done     <= 1'b1;
								res_q.fill_position <= '0;
								fill_q              <= '0;
								run_q               <= 1'b0;
							end
						end
					end
				end

				ST_READ: begin
					res_q.read_value <= read_in_range ? mem_rdata : '0;
					state_q          <= ST_HOLD;
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/packbits_line_decoder.sv -----
// PackBits line decoder. Each input word is either a feed of one encoded byte or a
// read of one stored element, selected by s_tuser, and every word yields exactly one
// result word. A byte that completes an element is written once per stored copy (up
// to 128 for a run), since the line store has a single write port and takes one
// element per cycle; no new word is accepted until every copy is written. A read
// passes through the registered read of the store. A finished result waits in the
// output register while the next word is accepted. The store is not cleared after
// reset: reading an entry never written returns garbage.
module packbits_line_decoder #(
	parameter int MAX_LINE = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: index 0 line_length, index 1 element_size_code.
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [pld_pkg::LEN_W-1:0]         cfg_data,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pld_pkg::S_TDATA_W-1:0]     s_tdata,  // data_byte[7:0], read_index[19:8]
	input  logic                              s_tuser,  // command[0]
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pld_pkg::M_TDATA_W-1:0]     m_tdata,  // fill_position[12:0], read_value[44:13]
	output logic                              m_tlast,  // line_done
	output logic                              m_tuser   // overflow_error[0]
);

	localparam int AW = $clog2(MAX_LINE);

	pld_pkg::item_t                  item;
	pld_pkg::result_t                res;
	logic                            res_valid;
	logic                            out_free;
	logic                            mem_we;
	logic [AW-1:0]                   mem_waddr;
	logic [pld_pkg::VALUE_W-1:0]     mem_wdata;
	logic [AW-1:0]                   mem_raddr;
	logic [pld_pkg::VALUE_W-1:0]     mem_rdata;

	// Unpack the input word.
	always_comb begin
		item.command    = s_tuser;
		item.data_byte  = s_tdata[7:0];
		item.read_index = s_tdata[19:8];
	end

	assign out_free = !m_tvalid || m_tready;

	pld_core #(
		.MAX_LINE (MAX_LINE)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	pld_ram #(
		.WIDTH (pld_pkg::VALUE_W),
		.DEPTH (MAX_LINE)
	) u_line_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: loads a result when free, holds it while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
			m_tuser  <= 1'b0;
		end else begin
			if (res_valid) begin
				m_tvalid <= 1'b1;
				m_tdata  <= pld_pkg::M_TDATA_W'({res.read_value, res.fill_position});
				m_tlast  <= res.line_done;
				m_tuser  <= res.overflow_error;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

// ----- src/pld_checker.sv -----
`include "assert_macros.svh"

module pld_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pld_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast,
	input logic                          m_tuser
);

	// A stalled result word keeps its contents.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// One word is decoded at a time: no accept right after an accept.
	`ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input accepted during decode")

	// A completed line and a refused byte never come together.
	`ASSERT_ALWAYS(a_done_xor_ovf, !(m_tvalid && m_tlast && m_tuser), "line done with overflow")

	// Both a completed line and an overflow leave an empty line behind.
	`ASSERT_SAME(a_restart_fill, m_tvalid && (m_tlast || m_tuser), m_tdata[12:0] == 13'd0, "fill not reset")

endmodule

bind packbits_line_decoder pld_checker u_checker (.*);
